// ===== rtl/core/bra_pkg.sv =====
// bra_pkg: shared types and constants for the bitmap run allocator
// used by the controller, the datapath and the top level
package bra_pkg;
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_RANGE = 2'd2;
	localparam logic [1:0] OP_FIND  = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [13:0] position;
		logic [14:0] range_end;
		logic        fill_bit;
		logic [14:0] run_length;
	} req_t;

	typedef struct packed {
		logic        read_bit;
		logic        found;
		logic [13:0] found_position;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;  // capture request, set up first word
		logic step;  // process current word, advance
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;  // current step is the final one for this item
	} sts_t;
endpackage

// ===== rtl/core/bitmap_run_allocator_unit.sv =====
// bitmap_run_allocator_unit: top level, built from bra_ctrl and bra_dpath
// bit read and bit write: after accept, a memory read state, then one word step; the result is registered
// range write and run search: one map word per cycle while no untaken result stalls
// the steps, over every map word; an empty range or an early hit ends sooner
// one word at a time; a result not yet taken stalls the word steps of the next word
// asynchronous active-low reset clears the map (per-word valid bits) and control
module bitmap_run_allocator_unit #(
	parameter int WORD_BITS = 64,
	parameter int NUM_WORDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // op, position, range_end, fill_bit, run_length
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_bit, found, found_position
);
	import bra_pkg::*;

	cmd_t cmd;
	sts_t sts;
	req_t req;
	rsp_t rsp;

	assign req.op         = s_tdata[1:0];
	assign req.position   = s_tdata[15:2];
	assign req.range_end  = s_tdata[30:16];
	assign req.fill_bit   = s_tdata[31];
	assign req.run_length = s_tdata[46:32];

	bra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .sts(sts)
	);

	bra_dpath #(.WORD_BITS(WORD_BITS), .NUM_WORDS(NUM_WORDS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp)
	);

	assign m_tdata = {rsp.found_position, rsp.found, rsp.read_bit};
endmodule

// ===== rtl/core/bra_ctrl.sv =====
// bra_ctrl: controller for the bitmap run allocator
// sequences load, word steps and the output register; uses bra_pkg
module bra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bra_pkg::cmd_t cmd,
	input  bra_pkg::sts_t sts
);
	import bra_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       done;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.step  = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign done      = cmd.step && sts.last;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (done)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_READ;
				ST_READ: state_q <= ST_RUN;
				ST_RUN:  if (done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/bra_dpath.sv =====
// bra_dpath: bit map memory and word-at-a-time range write and run search
// one memory read and one write per cycle; uses bra_pkg
module bra_dpath #(
	parameter int WORD_BITS = 64,
	parameter int NUM_WORDS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bra_pkg::req_t req,
	input  bra_pkg::cmd_t cmd,
	output bra_pkg::sts_t sts,
	output bra_pkg::rsp_t rsp
);
	import bra_pkg::*;

	localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int MAP_BITS = WORD_BITS * NUM_WORDS;
	localparam int PW = $clog2(MAP_BITS + 1) + 1;
	localparam int CW = (PW > 16) ? PW : 16;

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0] rdata_q;

	req_t          req_q;
	logic [AW-1:0] widx_q;
	logic [AW:0]   wcnt_q;
	logic [CW-1:0] count_q;
	rsp_t          rsp_q;

	logic [PW-1:0] pos_ext, end_clamp, base;
	logic          range_ok;
	logic [WORD_BITS-1:0] word_cur, word_new, sel, hitv;
	logic [BW:0]   zp [WORD_BITS];
	logic [BW:0]   zn [WORD_BITS];
	logic [CW-1:0] tot [WORD_BITS];
	logic [CW-1:0] cnt_c;
	logic          hit_c;
	logic [CW-1:0] hpos_c;
	logic [AW:0]   last_word;

	assign pos_ext = PW'(req_q.position);
	assign end_clamp = (PW'(req_q.range_end) > PW'(MAP_BITS)) ? PW'(MAP_BITS)
		: PW'(req_q.range_end);
	assign range_ok = (pos_ext < PW'(req_q.range_end)) && (pos_ext < PW'(MAP_BITS));
	assign base = PW'(widx_q) * PW'(WORD_BITS);
	assign word_cur = vld_q[widx_q] ? rdata_q : '0;

	always_comb begin
		word_new = word_cur;
		sel = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			sel[b] = ((base + PW'(b)) >= pos_ext) && ((base + PW'(b)) < end_clamp);
			if (sel[b]) word_new[b] = req_q.fill_bit;
		end
		if (req_q.op == OP_WRITE) begin
			word_new = word_cur;
			word_new[req_q.position[BW-1:0]] = req_q.fill_bit;
		end
	end

	// last mismatch at or below each bit, as index plus one, by a prefix max
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++)
			zp[b] = (word_cur[b] != req_q.fill_bit) ? (BW+1)'(b + 1) : '0;
		for (int lv = 0; lv < BW; lv++) begin
			for (int b = 0; b < WORD_BITS; b++)
				zn[b] = zp[b];
			for (int b = 1 << lv; b < WORD_BITS; b++)
				if (zp[b - (1 << lv)] > zp[b]) zn[b] = zp[b - (1 << lv)];
			for (int b = 0; b < WORD_BITS; b++)
				zp[b] = zn[b];
		end
		hitv = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			tot[b] = ((zp[b] == '0) ? count_q : '0) + CW'(b + 1) - CW'(zp[b]);
			hitv[b] = (req_q.run_length != '0) && (tot[b] >= CW'(req_q.run_length));
		end
		hit_c = |hitv;
		cnt_c = tot[WORD_BITS-1];
		hpos_c = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--)
			if (hitv[b]) hpos_c = CW'(base) + CW'(b + 1) - CW'(req_q.run_length);
	end

	always_comb begin
		case (req_q.op)
			OP_RANGE: last_word = (AW+1)'(NUM_WORDS - 1);
			OP_FIND:  last_word = (AW+1)'(NUM_WORDS - 1);
			default:  last_word = '0;
		endcase
		sts.last = (wcnt_q == last_word) || (req_q.op == OP_FIND && hit_c)
			|| (req_q.op == OP_RANGE && !range_ok);
	end

	logic          do_wr;
	assign do_wr = cmd.step && ((req_q.op == OP_WRITE
		&& PW'(req_q.position) < PW'(MAP_BITS)) || (req_q.op == OP_RANGE && range_ok));

	logic [AW-1:0] rd_addr;
	always_comb begin
		if (cmd.load) begin
			if (req.op == OP_READ || req.op == OP_WRITE)
				rd_addr = AW'(req.position >> BW);
			else
				rd_addr = '0;
		end else if (cmd.step) begin
			rd_addr = AW'(widx_q + 1'b1);
		end else begin
			rd_addr = widx_q;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (do_wr) mem[widx_q] <= word_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (do_wr) begin
			vld_q[widx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req;
			widx_q   <= (req.op == OP_READ || req.op == OP_WRITE)
				? AW'(req.position >> BW) : '0;
			wcnt_q   <= '0;
			count_q  <= '0;
		end else if (cmd.step) begin
			widx_q   <= AW'(widx_q + 1'b1);
			wcnt_q   <= wcnt_q + 1'b1;
			count_q  <= cnt_c;
		end
		if (cmd.step && sts.last) begin
			rsp_q.read_bit <= (req_q.op == OP_READ)
				&& (PW'(req_q.position) < PW'(MAP_BITS))
				&& word_cur[req_q.position[BW-1:0]];
			rsp_q.found <= (req_q.op == OP_FIND) && hit_c && (req_q.run_length != '0);
			rsp_q.found_position <= ((req_q.op == OP_FIND) && hit_c
				&& (req_q.run_length != '0)) ? hpos_c[13:0] : '0;
		end
	end

	assign rsp = rsp_q;
endmodule

// ===== rtl/core/bra_checker.sv =====
// bra_checker: port-level checks for bitmap_run_allocator_unit
// attached by bind; depends on nothing else
module bra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("busy");
	a_nofnd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[15:2] == 14'd0) else $error("pos");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1])) else $error("excl");
endmodule

bind bitmap_run_allocator_unit bra_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
